@@ hw/rtl/fca_pkg.sv @@
// Shared types and constants for the FIR convolution block.
// Holds the request and response payload structs and the control structs
// passed between the top level, the tap cells and the multiply-accumulate unit.
`default_nettype none

package fca_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COUNT_W      = 7;
   localparam int INDEX_W      = 6;
   localparam int TAPS_DEFAULT = 64;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic [INDEX_W-1:0]         tap_index;
      logic signed [SAMPLE_W-1:0] coefficient;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       last_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic rotate;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic en;
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/fir_convolution_audio.sv @@
// A sample request, taken only in idle, starts one full turn of the tap ring past the
// single multiplier, then a flush state; the output is registered in the emit state.
// Each tail output after a final sample takes a further turn. A load is taken in idle
// and starts no sum. No request is taken until idle again; an untaken response stalls emit.
// Reset clears all coefficients and history to zero and sets tap_count to 64.
// Depends on fca_pkg, fca_cell and fca_mac.
`default_nettype none

module fir_convolution_audio #(
   parameter int TAPS = fca_pkg::TAPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fca_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fca_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_en,
   input  logic [fca_pkg::COUNT_W-1:0]  csr_write_data
);
   import fca_pkg::*;

   localparam int CNT_W = $clog2(TAPS + 1);
   localparam int ACC_W = 2 * SAMPLE_W + $clog2(TAPS) + 1;
   localparam logic [31:0]      TAPS_WIDE = 32'(TAPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TAPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]     tail_ff, tail_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]   tap_count_ff, tap_count_in;

   logic [31:0]          tap_count_wide;
   logic [31:0]          active_wide;
   logic [CNT_W-1:0]     active_taps;
   logic                 req_fire;
   logic                 slot_free;
   cell_ctrl_type        cell_ctrl;
   mac_ctrl_type         mac_ctrl;
   logic signed [SAMPLE_W-1:0] shift_sample;
   logic signed [SAMPLE_W-1:0] mac_result;
   logic signed [SAMPLE_W-1:0] coef_chain   [TAPS];
   logic signed [SAMPLE_W-1:0] sample_chain [TAPS];

   assign tap_count_wide = {{(32-COUNT_W){1'b0}}, tap_count_ff};

   always_comb begin
      if (tap_count_ff == '0) begin
         active_wide = 32'd1;
      end else if (tap_count_wide > TAPS_WIDE) begin
         active_wide = TAPS_WIDE;
      end else begin
         active_wide = tap_count_wide;
      end
   end

   assign active_taps = active_wide[CNT_W-1:0];
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign slot_free   = ~rsp_valid_ff | rsp_ready;

   genvar gi;
   generate
      for (gi = 0; gi < TAPS; gi++) begin : g_cell
         localparam int NEXT = (gi + 1) % TAPS;
         localparam int PREV = (gi == 0) ? 0 : gi - 1;
         logic                       load_sel;
         logic signed [SAMPLE_W-1:0] shift_src;

         assign load_sel  = ({{(32-INDEX_W){1'b0}}, req_data.tap_index} == 32'(gi));
         assign shift_src = (gi == 0) ? shift_sample : sample_chain[PREV];

         fca_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (cell_ctrl),
            .load_sel      (load_sel),
            .load_coef     (req_data.coefficient),
            .shift_in      (shift_src),
            .rot_coef_in   (coef_chain[NEXT]),
            .rot_sample_in (sample_chain[NEXT]),
            .coef_out      (coef_chain[gi]),
            .sample_out    (sample_chain[gi])
         );
      end
   endgenerate

   fca_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (coef_chain[0]),
      .sample (sample_chain[0]),
      .result (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      tap_count_in = csr_write_en ? csr_write_data : tap_count_ff;
      cell_ctrl    = '0;
      mac_ctrl     = '0;
      shift_sample = req_data.sample;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_LOAD) begin
                  cell_ctrl.load = 1'b1;
               end else begin
                  cell_ctrl.shift = 1'b1;
                  mac_ctrl.clear  = 1'b1;
                  step_in         = '0;
                  tail_in         = req_data.last_sample ? active_taps - CNT_W'(1) : '0;
                  last_in         = req_data.last_sample;
                  state_in        = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cell_ctrl.rotate = 1'b1;
            mac_ctrl.en      = (step_ff < active_taps);
            if (step_ff == LAST_STEP) begin
               state_in = ST_FLUSH;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_sample = mac_result;
               rsp_data_in.last_out   = last_ff && (tail_ff == '0);
               if (tail_ff != '0) begin
                  tail_in         = tail_ff - CNT_W'(1);
                  shift_sample    = '0;
                  cell_ctrl.shift = 1'b1;
                  mac_ctrl.clear  = 1'b1;
                  step_in         = '0;
                  state_in        = ST_CALC;
               end else begin
                  cell_ctrl.clear = last_ff;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         tail_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= TAP_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_count_ff <= tap_count_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (step_ff <= LAST_STEP))
      else $error("tap ring step counter out of range");

   a_push_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == CMD_PUSH) |=> (state_ff == ST_CALC))
      else $error("accepted sample request did not start a sum");

   a_ring_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && step_ff == LAST_STEP) |=>
      (state_ff == ST_FLUSH && step_ff == LAST_STEP))
      else $error("tap ring turn did not end in flush");

endmodule

`default_nettype wire

@@ hw/rtl/fca_cell.sv @@
// One tap cell of the FIR chain: a coefficient and a delayed sample.
// Shifts samples along the delay line, rotates both values around the ring
// while a sum is formed, takes coefficient loads, and clears its sample. Depends on fca_pkg.
`default_nettype none

module fca_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  fca_pkg::cell_ctrl_type              ctrl,
   input  logic                                load_sel,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] load_coef,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] shift_in,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] rot_coef_in,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] rot_sample_in,
   output logic signed [fca_pkg::SAMPLE_W-1:0] coef_out,
   output logic signed [fca_pkg::SAMPLE_W-1:0] sample_out
);
   import fca_pkg::*;

   logic signed [SAMPLE_W-1:0] coef_ff;
   logic signed [SAMPLE_W-1:0] coef_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in;

   always_comb begin
      coef_in   = coef_ff;
      sample_in = sample_ff;
      if (ctrl.clear) begin
         sample_in = '0;
      end else if (ctrl.shift) begin
         sample_in = shift_in;
      end else if (ctrl.rotate) begin
         coef_in   = rot_coef_in;
         sample_in = rot_sample_in;
      end else if (ctrl.load && load_sel) begin
         coef_in = load_coef;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         sample_ff <= '0;
      end else begin
         coef_ff   <= coef_in;
         sample_ff <= sample_in;
      end
   end

   assign coef_out   = coef_ff;
   assign sample_out = sample_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fca_mac.sv @@
// Shared multiply-accumulate unit with truncation and saturation to Q1.15.
// Registers each product before it is added into the wide accumulator.
// Depends on fca_pkg.
`default_nettype none

module fca_mac #(
   parameter int ACC_W = 39
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fca_pkg::mac_ctrl_type               ctrl,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] coef,
   input  logic signed [fca_pkg::SAMPLE_W-1:0] sample,
   output logic signed [fca_pkg::SAMPLE_W-1:0] result
);
   import fca_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int FRAC_W = SAMPLE_W - 1;
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(SAMPLE_MIN);

   logic signed [PROD_W-1:0] mult_ff;
   logic                     mult_en_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  quot;
   logic signed [ACC_W-1:0]  quot_adj;
   logic                     round_up;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (mult_en_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){mult_ff[PROD_W-1]}}, mult_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_en_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         mult_en_ff <= ctrl.en;
         acc_ff     <= acc_in;
      end
      mult_ff <= coef * sample;
   end

   // The shift by 2^15 rounds down, so negative sums with a fraction step up by one to round towards zero.
   always_comb begin
      quot     = acc_ff >>> FRAC_W;
      round_up = acc_ff[ACC_W-1] & (|acc_ff[FRAC_W-1:0]);
      quot_adj = quot + {{(ACC_W-1){1'b0}}, round_up};
      if (quot_adj > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_W-1:0];
      end else if (quot_adj < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         result = quot_adj[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ tb/tb_fir_convolution_audio.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fir_convolution_audio: a directed table followed by random phases.
// Depends on fca_pkg for the request and response types and on the block itself.

module tb_fir_convolution_audio;
   import fca_pkg::*;

   localparam int TAPS = TAPS_DEFAULT;
   localparam int DRAIN_CYCLES = 2 * (TAPS + 2);
   localparam int HOLD_CYCLES = 10 * (TAPS + 2);
   localparam int PHASES = 10;
   localparam int PRESSURE_PHASE = 4;
   localparam int STEADY_PHASE = 5;
   localparam int DIRECTED_ROWS = 15;
   localparam logic [COUNT_W-1:0] PHASE_TAPS [PHASES] = '{
      7'd1, 7'd0, 7'd3, 7'd127, 7'd2, 7'd64, 7'd65, 7'd8, 7'd5, 7'd16
   };

   typedef struct {
      req_type request;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   // A typed value stands where the output can be read off directly: zero coefficients
   // after reset, both saturation limits, and truncation towards zero.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{CMD_PUSH, 6'h3F, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
      '{'{CMD_PUSH, 6'h00, 16'h8000, 16'h8000, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h00, 16'h7FFF, 16'h1234, 1'b1}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h01, 16'h8000, 16'h0000, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h3F, 16'h7FFF, 16'hFFFF, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_PUSH, 6'h2A, 16'h5555, 16'h7FFF, 1'b0}, 1'b1, '{16'h7FFF, 1'b0}},
      '{'{CMD_PUSH, 6'h15, 16'hAAAA, 16'h8000, 1'b0}, 1'b1, '{16'h8000, 1'b0}},
      '{'{CMD_PUSH, 6'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h01, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h3F, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h00, 16'h0001, 16'h0000, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_PUSH, 6'h00, 16'h0000, 16'hFFFF, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
      '{'{CMD_LOAD, 6'h00, 16'h8000, 16'h0000, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
      '{'{CMD_PUSH, 6'h00, 16'h0000, 16'h8000, 1'b0}, 1'b1, '{16'h7FFF, 1'b0}},
      '{'{CMD_PUSH, 6'h00, 16'h0000, 16'h7FFF, 1'b1}, 1'b0, '{16'h0000, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   bit req_typed = 1'b0;
   rsp_type req_want = '0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   int mismatch_count = 0;

   logic signed [SAMPLE_W-1:0] coef_model [TAPS] = '{default: '0};
   logic signed [SAMPLE_W-1:0] history_model [TAPS] = '{default: '0};
   logic [COUNT_W-1:0] tap_count_model = TAP_COUNT_RESET;
   rsp_type expected_outputs [$];

   fir_convolution_audio #(.TAPS(TAPS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin : convolution_predictor
      int taps_in_use;
      int outputs;
      longint acc;
      longint quotient;
      rsp_type result;
      if (!reset && req_valid && req_ready) begin
         if (req_data.cmd == CMD_LOAD) begin
            if (int'(req_data.tap_index) < TAPS) begin
               coef_model[req_data.tap_index] = req_data.coefficient;
            end
         end else begin
            taps_in_use = (tap_count_model == 0) ? 1 :
                          (tap_count_model > TAPS) ? TAPS : int'(tap_count_model);
            outputs = req_data.last_sample ? taps_in_use : 1;
            for (int k = 0; k < outputs; k++) begin
               for (int i = TAPS - 1; i > 0; i--) begin
                  history_model[i] = history_model[i - 1];
               end
               history_model[0] = (k == 0) ? req_data.sample : '0;
               acc = 0;
               for (int i = 0; i < taps_in_use; i++) begin
                  acc += longint'(coef_model[i]) * longint'(history_model[i]);
               end
               quotient = acc / 32768;
               if (quotient > SAMPLE_MAX) begin
                  quotient = SAMPLE_MAX;
               end else if (quotient < SAMPLE_MIN) begin
                  quotient = SAMPLE_MIN;
               end
               result.out_sample = quotient[SAMPLE_W-1:0];
               result.last_out = req_data.last_sample && (k == outputs - 1);
               if (k == 0 && req_typed) begin
                  result = req_want;
               end
               expected_outputs.push_back(result);
            end
            if (req_data.last_sample) begin
               for (int i = 0; i < TAPS; i++) begin
                  history_model[i] = '0;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : output_check
      rsp_type oldest;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $error("out_sample: no output expected, actual %0d", rsp_data.out_sample);
            mismatch_count++;
         end else begin
            oldest = expected_outputs.pop_front();
            if (rsp_data.out_sample !== oldest.out_sample) begin
               $error("out_sample: expected %0d, actual %0d",
                      oldest.out_sample, rsp_data.out_sample);
               mismatch_count++;
            end
            if (rsp_data.last_out !== oldest.last_out) begin
               $error("last_out: expected %0d, actual %0d", oldest.last_out, rsp_data.last_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : output_receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 33);
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] random_word();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return SAMPLE_W'($urandom_range(16)) - 16'd8;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic offer(input req_type request, input bit typed, input rsp_type want);
      if (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 33);
      end
      req_data <= request;
      req_typed <= typed;
      req_want <= want;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [COUNT_W-1:0] value);
      csr_write_data <= value;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tap_count_model = value;
   endtask

   // Each phase opens with coefficient loads, then mostly sample runs closed by a final
   // sample; a phase may stop mid-signal so that the new tap count meets kept history.
   task automatic run_phase(input logic [COUNT_W-1:0] taps, input int items);
      int reach;
      req_type request;
      write_tap_count(taps);
      reach = (taps == 0) ? 1 : (taps > TAPS) ? TAPS : int'(taps);
      for (int n = 0; n < items; n++) begin
         request.tap_index = INDEX_W'($urandom);
         request.coefficient = random_word();
         request.sample = random_word();
         request.last_sample = (n == items - 1) ? ($urandom_range(3) != 0) :
                               ($urandom_range(99) < 18);
         if (n < 3 || $urandom_range(99) < 15) begin
            request.cmd = CMD_LOAD;
            if ($urandom_range(99) < 75) begin
               request.tap_index = INDEX_W'($urandom_range(reach - 1, 0));
            end
         end else begin
            request.cmd = CMD_PUSH;
         end
         offer(request, 1'b0, '0);
      end
      settle();
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer(directed_rows[i].request, directed_rows[i].typed, directed_rows[i].want);
      end
      settle();
      for (int p = 0; p < PHASES; p++) begin
         steady = (p == PRESSURE_PHASE) || (p == STEADY_PHASE);
         hold_request = (p == PRESSURE_PHASE);
         run_phase(PHASE_TAPS[p], (p == PRESSURE_PHASE) ? 24 : 14);
      end
      steady = 1'b0;
      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("fir_convolution_audio test passed");
      end else begin
         $display("fir_convolution_audio test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(64'd80_000_000);
      $display("fir_convolution_audio test failed");
      $finish;
   end

endmodule
